// ===== src/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and codes of the ordered list engine: request and result
// records, operation codes and status codes.
// ----------------------------------------------------------------------------
package ole_pkg;

  // fixed field widths of the channels
  localparam int OP_W    = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 11;
  localparam int CNT_O_W = 11;
  localparam int ST_W    = 2;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [CNT_O_W-1:0] cnt_out_t;
  typedef logic [ST_W-1:0]    status_t;

  // operation codes
  localparam op_t OP_PUSH_FRONT = 3'd0;
  localparam op_t OP_PUSH_BACK  = 3'd1;
  localparam op_t OP_INSERT_AT  = 3'd2;
  localparam op_t OP_DEL_FIRST  = 3'd3;
  localparam op_t OP_DEL_LAST   = 3'd4;
  localparam op_t OP_DEL_AT     = 3'd5;
  localparam op_t OP_DEL_VALUE  = 3'd6;
  localparam op_t OP_SEARCH     = 3'd7;

  // status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  // one request as it enters the sequencer
  typedef struct packed {
    op_t                     opcode;
    logic signed [VAL_W-1:0] data_value;
    pos_t                    position;
  } req_t;

  // one result as it leaves the sequencer
  typedef struct packed {
    logic     found;
    cnt_out_t entry_count;
    status_t  status;
  } res_t;

endpackage

// ===== src/ole_store.sv =====
// ----------------------------------------------------------------------------
// ole_store
// Entry memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ole_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic signed [ole_pkg::VAL_W-1:0] wr_data,
  input  logic [AW-1:0]                  rd_addr,
  output logic signed [ole_pkg::VAL_W-1:0] rd_data
);

  logic signed [ole_pkg::VAL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/ole_ctrl.sv =====
// ----------------------------------------------------------------------------
// ole_ctrl
// Sequencer of the list: shifts entries up or down one per cycle through
// the store, and scans for a value with a single comparator.
// ----------------------------------------------------------------------------
module ole_ctrl #(
  parameter int CAPACITY = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            req_valid,
  input  ole_pkg::req_t   req,
  output logic            req_ready,
  output logic            res_valid,
  input  logic            res_ready,
  output ole_pkg::res_t   res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_DN   = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              cur_r, cur_nxt;
  logic [CW-1:0]              at_r, at_nxt;
  logic                       wpend_r, wpend_nxt;
  logic [AW-1:0]              waddr_r, waddr_nxt;
  logic                       rvalid_r, rvalid_nxt;
  logic [AW-1:0]              raddr_r, raddr_nxt;
  ole_pkg::op_t               op_r, op_nxt;
  logic signed [ole_pkg::VAL_W-1:0] value_r, value_nxt;
  logic                       found_r, found_nxt;
  ole_pkg::status_t           status_r, status_nxt;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic signed [ole_pkg::VAL_W-1:0] wr_data;
  logic [AW-1:0]              rd_addr;
  logic signed [ole_pkg::VAL_W-1:0] rd_data;

  logic [PW-1:0]              pos_ext;
  logic [PW-1:0]              cnt_ext;
  logic [PW-1:0]              last_ext;
  logic                       hit;

  ole_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // position clamping terms
  assign pos_ext  = PW'(req.position);
  assign cnt_ext  = PW'(count_r);
  assign last_ext = cnt_ext - PW'(1);

  // shared comparator of the scan
  assign hit = rvalid_r && (rd_data == value_r);

  // handshake toward the top level
  assign req_ready       = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_FIN);
  assign res.found       = found_r;
  assign res.entry_count = ole_pkg::cnt_out_t'(count_r);
  assign res.status      = status_r;

  // next-state and datapath control
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    at_nxt     = at_r;
    wpend_nxt  = wpend_r;
    waddr_nxt  = waddr_r;
    rvalid_nxt = 1'b0;
    raddr_nxt  = raddr_r;
    op_nxt     = op_r;
    value_nxt  = value_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = waddr_r;
    wr_data    = rd_data;
    rd_addr    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt     = req.opcode;
          value_nxt  = req.data_value;
          found_nxt  = 1'b0;
          status_nxt = ole_pkg::ST_OK;
          wpend_nxt  = 1'b0;
          priority if (req.opcode == ole_pkg::OP_PUSH_FRONT ||
                       req.opcode == ole_pkg::OP_PUSH_BACK ||
                       req.opcode == ole_pkg::OP_INSERT_AT) begin
            if (count_r == CW'(CAPACITY)) begin
              status_nxt = ole_pkg::ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              priority if (req.opcode == ole_pkg::OP_PUSH_FRONT) begin
                at_nxt = '0;
              end else if (req.opcode == ole_pkg::OP_PUSH_BACK) begin
                at_nxt = count_r;
              end else begin
                at_nxt = (pos_ext < cnt_ext) ? CW'(pos_ext) : count_r;
              end
              cur_nxt   = count_r;
              state_nxt = S_UP;
            end
          end else if (count_r == '0) begin
            status_nxt = ole_pkg::ST_EMPTY;
            state_nxt  = S_FIN;
          end else if (req.opcode == ole_pkg::OP_DEL_FIRST) begin
            cur_nxt   = '0;
            state_nxt = S_DN;
          end else if (req.opcode == ole_pkg::OP_DEL_LAST) begin
            cur_nxt   = CW'(last_ext);
            state_nxt = S_DN;
          end else if (req.opcode == ole_pkg::OP_DEL_AT) begin
            cur_nxt   = (pos_ext < last_ext) ? CW'(pos_ext) : CW'(last_ext);
            state_nxt = S_DN;
          end else begin
            cur_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      // open a gap at at_r, moving entries up from the back
      S_UP: begin
        if (wpend_r) begin
          wr_en = 1'b1;
        end else if (cur_r == at_r) begin
          wr_en   = 1'b1;
          wr_addr = at_r[AW-1:0];
          wr_data = value_r;
        end
        if (cur_r > at_r) begin
          rd_addr   = AW'(cur_r - CW'(1));
          wpend_nxt = 1'b1;
          waddr_nxt = cur_r[AW-1:0];
          cur_nxt   = cur_r - CW'(1);
        end else if (wpend_r) begin
          wpend_nxt = 1'b0;
        end else begin
          count_nxt = count_r + CW'(1);
          state_nxt = S_FIN;
        end
      end

      // close the gap at the cursor, moving entries down toward it
      S_DN: begin
        if (wpend_r) begin
          wr_en = 1'b1;
        end
        if ((cur_r + CW'(1)) < count_r) begin
          rd_addr   = AW'(cur_r + CW'(1));
          wpend_nxt = 1'b1;
          waddr_nxt = cur_r[AW-1:0];
          cur_nxt   = cur_r + CW'(1);
        end else if (wpend_r) begin
          wpend_nxt = 1'b0;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end
      end

      // read one entry a cycle and compare the one read before
      S_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          if (op_r == ole_pkg::OP_DEL_VALUE) begin
            cur_nxt   = CW'(raddr_r);
            wpend_nxt = 1'b0;
            state_nxt = S_DN;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (cur_r < count_r) begin
          rd_addr    = cur_r[AW-1:0];
          rvalid_nxt = 1'b1;
          raddr_nxt  = cur_r[AW-1:0];
          cur_nxt    = cur_r + CW'(1);
        end else begin
          status_nxt = ole_pkg::ST_NOT_FOUND;
          state_nxt  = S_FIN;
        end
      end

      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      wpend_r  <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      wpend_r  <= wpend_nxt;
      rvalid_r <= rvalid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    at_r     <= at_nxt;
    waddr_r  <= waddr_nxt;
    raddr_r  <= raddr_nxt;
    op_r     <= op_nxt;
    value_r  <= value_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

endmodule

// ===== src/ordered_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Ordered list of signed 32-bit values with front, back and positional
// insert and delete, delete by value and search.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream: opcode on in_tuser, value and position
//   on in_tdata. Every request yields exactly one transaction on the out_
//   stream carrying found, the entry count after the request and a status.
//   Entries sit packed front first in a single-port-write, single-port-read
//   memory; a sequencer moves them one slot per cycle through that port.
//   An insert into a full list and a delete or search on an empty list go
//   straight to the result. An insert moves every entry from the slot to
//   the back up one slot, back first; a delete moves every entry behind
//   the slot down one. A search reads entries from the front until a
//   match or the end; delete by value searches, then deletes the match.
//   While busy, in_tready is low; it rises again once the result is
//   registered.
//   A finished result waits in the output register while the next request
//   is taken; if the receiver stalls, the sequencer holds its result until
//   the register frees. Reset empties the list at once (count zero) and
//   needs no clearing pass; entry contents are not reset.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // data_value[31:0], position[42:32], zero pad
  input  logic [7:0]  in_tuser,   // opcode[2:0], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // found[0], entry_count[11:1], status[13:12], pad
);

  ole_pkg::req_t req;
  ole_pkg::res_t res;
  ole_pkg::res_t res_r;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_r;

  // unpack the request
  assign req.opcode     = in_tuser[ole_pkg::OP_W-1:0];
  assign req.data_value = in_tdata[31:0];
  assign req.position   = in_tdata[42:32];

  ole_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register takes a result whenever it is empty or draining
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  // pack the result transaction
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.status, res_r.entry_count, res_r.found};

endmodule
